### hdl/arm_ik_pkg.sv
// ----------------------------------------------------------------------------
// arm_ik_pkg
// Shared types, constants and step functions for the arm joint step pipeline.
// ----------------------------------------------------------------------------
package arm_ik_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STAGES  = 16;     // one root bit per stage, 32 bit radicand
	localparam int CW           = 38;     // cordic x/y datapath width
	localparam int AW           = 32;     // angle width, Q.30 radians
	localparam int XW           = 34;     // widened angle for the joint sums
	localparam int ANG_FRAC     = 30;
	localparam int CPR_FRAC     = 4;
	localparam int PW           = XW - 1 + 16;
	localparam int PSH          = ANG_FRAC + CPR_FRAC;

	localparam logic signed [XW-1:0] HALF_PI         = 34'sd1686629711;
	localparam logic signed [17:0]   BASE_OFFSET     = 18'sd1768;
	localparam logic signed [17:0]   SHOULDER_OFFSET = 18'sd1100;

	typedef enum logic [2:0] {
		REG_BASE_HEIGHT  = 3'd0,
		REG_LINK_LENGTH  = 3'd1,
		REG_BASE_CPR     = 3'd2,
		REG_SHOULDER_CPR = 3'd3,
		REG_ELBOW_CPR    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] op;
		logic [17:0] r;
		logic [15:0] q;
	} sqrt_lane_t;

	typedef struct packed {
		logic               oor;
		logic signed [16:0] xb;
		logic signed [16:0] yb;
		logic signed [17:0] z0;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [AW-1:0] z;
		logic                 zz;
	} cord_t;

	function automatic logic signed [AW-1:0] atan_entry(input int i);
		case (i)
			0:  return 32'sd843314856;
			1:  return 32'sd497837829;
			2:  return 32'sd263043836;
			3:  return 32'sd133525158;
			4:  return 32'sd67021686;
			5:  return 32'sd33543515;
			6:  return 32'sd16775850;
			7:  return 32'sd8388437;
			8:  return 32'sd4194282;
			9:  return 32'sd2097149;
			10: return 32'sd1048575;
			11: return 32'sd524287;
			12: return 32'sd262143;
			13: return 32'sd131071;
			14: return 32'sd65535;
			15: return 32'sd32767;
			16: return 32'sd16383;
			17: return 32'sd8191;
			18: return 32'sd4095;
			19: return 32'sd2047;
			20: return 32'sd1023;
			21: return 32'sd511;
			22: return 32'sd255;
			23: return 32'sd127;
			default: return 32'sd0;
		endcase
	endfunction

	// one restoring root digit: bring down two radicand bits, try (4q+1)
	function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t a);
		logic [19:0] rt;
		logic [19:0] t;
		sqrt_lane_t  b;
		rt   = {a.r, a.op[31:30]};
		t    = {2'b00, a.q, 2'b01};
		b.op = {a.op[29:0], 2'b00};
		if (rt >= t) begin
			b.r = 18'(rt - t);
			b.q = {a.q[14:0], 1'b1};
		end else begin
			b.r = rt[17:0];
			b.q = {a.q[14:0], 1'b0};
		end
		return b;
	endfunction

	// one vectoring rotation, shifts floor
	function automatic cord_t cord_step(input cord_t a, input int i);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		cord_t                b;
		dx = a.cy >>> i;
		dy = a.cx >>> i;
		b  = a;
		if (!a.cy[CW-1]) begin
			b.cx = a.cx + dx;
			b.cy = a.cy - dy;
			b.z  = a.z + atan_entry(i);
		end else begin
			b.cx = a.cx - dx;
			b.cy = a.cy + dy;
			b.z  = a.z - atan_entry(i);
		end
		return b;
	endfunction

endpackage

### hdl/arm_ik_joint_steps.sv
// throughput: one target per cycle; a stalled master side freezes every stage
// stages: input, squares, sums/reach test, 16 root-bit stages, load plus
// 16 cordic rotation stages, joint angles, counts multiply, saturate/output
// reset: valid bits clear, registers return to their reset values
// ----------------------------------------------------------------------------
// arm_ik_joint_steps
// Two-link arm inverse kinematics to base, shoulder and elbow step counts.
// ----------------------------------------------------------------------------
module arm_ik_joint_steps import arm_ik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // target_x, target_y, target_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // base_step, shoulder_step, elbow_step
	output logic [0:0]  m_tuser,   // out_of_reach
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [14:0] bh_q, ll_q;
	logic [15:0] cpr_q [3];

	logic adv;

	logic signed [15:0] x_s1, y_s1, x_s2, y_s2;
	logic signed [17:0] z0_s1, z0_s2;
	logic [31:0] xx_s2, yy_s2, zz_s2;
	logic [29:0] ll_s2;
	logic v_s1, v_s2;

	sqrt_lane_t sq_sn [SQRT_STAGES+1][3];
	side_t      sd_sn [SQRT_STAGES+1];
	logic [SQRT_STAGES:0] v_sq_sn;

	cord_t cd_sn [CORDIC_STEPS+1][3];
	logic [CORDIC_STEPS:0] oor_cd_sn;
	logic [CORDIC_STEPS:0] v_cd_sn;

	logic signed [XW-1:0] ang_s37 [3];
	logic oor_s37, v_s37;
	logic [PW-1:0] prd_s38 [3];
	logic [2:0] neg_s38;
	logic oor_s38, v_s38;
	logic [15:0] stp_s39 [3];
	logic oor_s39, v_s39;

	// combinational helpers
	logic [33:0] d2;
	logic [31:0] lim, xy2;
	logic signed [16:0] xe, ye;
	logic signed [XW-1:0] phi [3];
	logic [XW-1:0] mag [3];
	logic signed [17:0] sv [3];
	logic signed [17:0] sum [3];
	logic signed [17:0] offs [3];

	assign adv      = !v_s39 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s39;
	assign m_tdata  = {stp_s39[2], stp_s39[1], stp_s39[0]};
	assign m_tuser  = oor_s39;
	assign pready   = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bh_q      <= 15'd3744;
			ll_q      <= 15'd1792;
			cpr_q[0]  <= 16'd18000;
			cpr_q[1]  <= 16'd18000;
			cpr_q[2]  <= 16'd18000;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_BASE_HEIGHT:  bh_q     <= pwdata[14:0];
				REG_LINK_LENGTH:  ll_q     <= pwdata[14:0];
				REG_BASE_CPR:     cpr_q[0] <= pwdata[15:0];
				REG_SHOULDER_CPR: cpr_q[1] <= pwdata[15:0];
				REG_ELBOW_CPR:    cpr_q[2] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_BASE_HEIGHT:  prdata = 32'(bh_q);
			REG_LINK_LENGTH:  prdata = 32'(ll_q);
			REG_BASE_CPR:     prdata = 32'(cpr_q[0]);
			REG_SHOULDER_CPR: prdata = 32'(cpr_q[1]);
			REG_ELBOW_CPR:    prdata = 32'(cpr_q[2]);
			default:          prdata = 32'd0;
		endcase
	end

	// reach test and radicands
	always_comb begin
		xy2 = xx_s2 + yy_s2;
		d2  = 34'(xx_s2) + 34'(yy_s2) + 34'(zz_s2);
		lim = {ll_s2, 2'b00};
		xe  = 17'(x_s2);
		ye  = 17'(y_s2);
	end

	// joint angles and final scaling
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			phi[j] = cd_sn[CORDIC_STEPS][j].zz ? '0 : XW'(cd_sn[CORDIC_STEPS][j].z);
			mag[j] = ang_s37[j][XW-1] ? XW'(-ang_s37[j]) : XW'(ang_s37[j]);
			sv[j]  = neg_s38[j] ? 18'sd0 - $signed({3'b000, prd_s38[j][PW-1:PSH]})
			                    : $signed({3'b000, prd_s38[j][PW-1:PSH]});
		end
		offs[0] = BASE_OFFSET;
		offs[1] = SHOULDER_OFFSET;
		offs[2] = 18'sd0;
		for (int j = 0; j < 3; j++) begin
			sum[j] = sv[j] + offs[j];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= s_tdata[15:0];
			y_s1  <= s_tdata[31:16];
			z0_s1 <= $signed({{2{s_tdata[47]}}, s_tdata[47:32]}) - $signed({3'b000, bh_q});

			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z0_s2 <= z0_s1;
			xx_s2 <= 32'(x_s1 * x_s1);
			yy_s2 <= 32'(y_s1 * y_s1);
			zz_s2 <= 32'(z0_s1 * z0_s1);
			ll_s2 <= 30'(ll_q * ll_q);

			sq_sn[0][0]  <= '{op: xy2, r: '0, q: '0};
			sq_sn[0][1]  <= '{op: d2[31:0], r: '0, q: '0};
			sq_sn[0][2]  <= '{op: lim - d2[31:0], r: '0, q: '0};
			sd_sn[0].oor <= d2 > 34'(lim);
			sd_sn[0].xb  <= x_s2[15] ? -xe : xe;
			sd_sn[0].yb  <= x_s2[15] ? -ye : ye;
			sd_sn[0].z0  <= z0_s2;

			for (int k = 0; k < SQRT_STAGES; k++) begin
				for (int j = 0; j < 3; j++) begin
					sq_sn[k+1][j] <= sqrt_step(sq_sn[k][j]);
				end
				sd_sn[k+1] <= sd_sn[k];
			end

			// lane 0 elbow half angle, lane 1 elevation, lane 2 base
			cd_sn[0][0].cx <= {{(CW-32){1'b0}}, sq_sn[SQRT_STAGES][1].q, 16'h0};
			cd_sn[0][0].cy <= {{(CW-32){1'b0}}, sq_sn[SQRT_STAGES][2].q, 16'h0};
			cd_sn[0][0].zz <= sq_sn[SQRT_STAGES][1].q == '0 && sq_sn[SQRT_STAGES][2].q == '0;
			cd_sn[0][1].cx <= {{(CW-32){1'b0}}, sq_sn[SQRT_STAGES][0].q, 16'h0};
			cd_sn[0][1].cy <= {{(CW-34){sd_sn[SQRT_STAGES].z0[17]}},
			                   sd_sn[SQRT_STAGES].z0, 16'h0};
			cd_sn[0][1].zz <= sq_sn[SQRT_STAGES][0].q == '0 && sd_sn[SQRT_STAGES].z0 == '0;
			cd_sn[0][2].cx <= {{(CW-33){sd_sn[SQRT_STAGES].xb[16]}},
			                   sd_sn[SQRT_STAGES].xb, 16'h0};
			cd_sn[0][2].cy <= {{(CW-33){sd_sn[SQRT_STAGES].yb[16]}},
			                   sd_sn[SQRT_STAGES].yb, 16'h0};
			cd_sn[0][2].zz <= sd_sn[SQRT_STAGES].xb == '0 && sd_sn[SQRT_STAGES].yb == '0;
			for (int j = 0; j < 3; j++) begin
				cd_sn[0][j].z <= '0;
			end
			oor_cd_sn[0] <= sd_sn[SQRT_STAGES].oor;

			for (int k = 0; k < CORDIC_STEPS; k++) begin
				for (int j = 0; j < 3; j++) begin
					cd_sn[k+1][j] <= cord_step(cd_sn[k][j], k);
				end
				oor_cd_sn[k+1] <= oor_cd_sn[k];
			end

			ang_s37[0] <= phi[2];
			ang_s37[1] <= HALF_PI - (phi[0] + phi[1]);
			ang_s37[2] <= HALF_PI - (phi[1] - phi[0]);
			oor_s37    <= oor_cd_sn[CORDIC_STEPS];

			for (int j = 0; j < 3; j++) begin
				prd_s38[j] <= mag[j][XW-2:0] * cpr_q[j];
				neg_s38[j] <= ang_s37[j][XW-1];
			end
			oor_s38 <= oor_s37;

			for (int j = 0; j < 3; j++) begin
				if (oor_s38)
					stp_s39[j] <= 16'hFFFF;
				else if (sum[j] > 18'sd32767)
					stp_s39[j] <= 16'h7FFF;
				else if (sum[j] < -18'sd32768)
					stp_s39[j] <= 16'h8000;
				else
					stp_s39[j] <= sum[j][15:0];
			end
			oor_s39 <= oor_s38;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_sq_sn <= '0;
			v_cd_sn <= '0;
			v_s37   <= 1'b0;
			v_s38   <= 1'b0;
			v_s39   <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_sq_sn <= {v_sq_sn[SQRT_STAGES-1:0], v_s2};
			v_cd_sn <= {v_cd_sn[CORDIC_STEPS-1:0], v_sq_sn[SQRT_STAGES]};
			v_s37   <= v_cd_sn[CORDIC_STEPS];
			v_s38   <= v_s37;
			v_s39   <= v_s38;
		end
	end

`ifndef NO_ASSERTIONS
	a_oor_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '1)
		else $error("unreachable target without all-ones steps");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_sq_sn, v_cd_sn, v_s37, v_s38, v_s39}))
		else $error("pipeline valid bits moved during a stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction missing from first stage");
`endif

endmodule

### tb/arm_ik_checker.sv
// ----------------------------------------------------------------------------
// arm_ik_checker
// Watches the target and step streams of the joint step pipeline, computes the
// expected step counts for each accepted target and compares them in order.
// ----------------------------------------------------------------------------
module arm_ik_checker import arm_ik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        oor;
		logic [15:0] elbow;
		logic [15:0] shoulder;
		logic [15:0] base;
	} joint_steps_t;

	logic [14:0] base_height;
	logic [14:0] link_length;
	logic [15:0] base_cpr;
	logic [15:0] shoulder_cpr;
	logic [15:0] elbow_cpr;

	joint_steps_t steps_q[$];

	localparam longint ATAN_Q30[16] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535, 32767};

	assign pending = steps_q.size();

	function automatic longint int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// vectoring arctangent in q.30 radians, x is never negative
	function automatic longint vector_angle(longint yv, longint xv);
		longint cx;
		longint cy;
		longint ang;
		longint dx;
		longint dy;
		if (yv == 0 && xv == 0) return 0;
		cx = xv * 65536;
		cy = yv * 65536;
		ang = 0;
		for (int i = 0; i < 16; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				ang += ATAN_Q30[i];
			end else begin
				cx -= dx;
				cy += dy;
				ang -= ATAN_Q30[i];
			end
		end
		return ang;
	endfunction

	function automatic logic [15:0] angle_to_count(longint ang, logic [15:0] cpr,
			longint offset);
		longint unsigned mag;
		longint c;
		mag = ang < 0 ? longint'(-ang) : ang;
		c = longint'((mag * longint'(cpr)) >> 34);
		if (ang < 0) c = -c;
		c += offset;
		if (c > 32767) c = 32767;
		if (c < -32768) c = -32768;
		return c[15:0];
	endfunction

	function automatic joint_steps_t predict_steps(logic [47:0] tgt);
		longint x;
		longint y;
		longint z0;
		longint xy2;
		longint d2;
		longint lim;
		longint phi1;
		longint phi3;
		longint theta1;
		joint_steps_t r;
		x = longint'($signed(tgt[15:0]));
		y = longint'($signed(tgt[31:16]));
		z0 = longint'($signed(tgt[47:32])) - longint'(base_height);
		xy2 = x * x + y * y;
		d2 = xy2 + z0 * z0;
		lim = 4 * longint'(link_length) * longint'(link_length);
		if (d2 > lim) begin
			r = '{oor: 1'b1, elbow: 16'hFFFF, shoulder: 16'hFFFF, base: 16'hFFFF};
			return r;
		end
		phi1 = vector_angle(int_root(lim - d2), int_root(d2));
		phi3 = vector_angle(z0, int_root(xy2));
		theta1 = x < 0 ? vector_angle(-y, -x) : vector_angle(y, x);
		r.oor = 1'b0;
		r.base = angle_to_count(theta1, base_cpr, 1768);
		r.shoulder = angle_to_count(1686629711 - (phi1 + phi3), shoulder_cpr, 1100);
		r.elbow = angle_to_count(1686629711 - (phi3 - phi1), elbow_cpr, 0);
		return r;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what,
			$signed(got), $signed(want), $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		joint_steps_t e;
		if (!arst_n) begin
			base_height  <= 15'd3744;
			link_length  <= 15'd1792;
			base_cpr     <= 16'd18000;
			shoulder_cpr <= 16'd18000;
			elbow_cpr    <= 16'd18000;
			fail_count   = 0;
			steps_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (steps_q.size() == 0) begin
					$display("unexpected step transaction at %0t", $realtime);
					fail_count++;
				end else begin
					e = steps_q.pop_front();
					if (m_tdata[15:0] !== e.base) report("base", m_tdata[15:0], e.base);
					if (m_tdata[31:16] !== e.shoulder)
						report("shoulder", m_tdata[31:16], e.shoulder);
					if (m_tdata[47:32] !== e.elbow) report("elbow", m_tdata[47:32], e.elbow);
					if (m_tuser[0] !== e.oor)
						report("out_of_reach", 16'(m_tuser), 16'(e.oor));
				end
			end
			if (s_tvalid && s_tready) steps_q.push_back(predict_steps(s_tdata));
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_BASE_HEIGHT:  base_height  <= pwdata[14:0];
					REG_LINK_LENGTH:  link_length  <= pwdata[14:0];
					REG_BASE_CPR:     base_cpr     <= pwdata[15:0];
					REG_SHOULDER_CPR: shoulder_cpr <= pwdata[15:0];
					REG_ELBOW_CPR:    elbow_cpr    <= pwdata[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives target points and register settings into the joint step pipeline
// with random stalls on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb import arm_ik_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;      // target_x, target_y, target_z
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // base_step, shoulder_step, elbow_step
	logic [0:0]  m_tuser;           // out_of_reach
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	bit          allow_idle = 1'b1;

	always #2 clk = ~clk;

	arm_ik_joint_steps u_dut (.*);

	arm_ik_checker u_chk (.*);

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_target(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	// random targets, mostly inside a cube of half-side reach around (0, 0, 3744)
	task automatic random_targets(int n, int reach);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				send_target(16'($signed($urandom_range(0, 2 * reach)) - reach),
					16'($signed($urandom_range(0, 2 * reach)) - reach),
					16'($signed($urandom_range(0, 2 * reach)) - reach + 3744));
			else
				send_target(16'($urandom), 16'($urandom), 16'($urandom));
		end
		s_tvalid <= 1'b0;
	endtask

	// master side drops ready in random bursts while allow_idle is set
	always begin
		@(negedge clk);
		if (allow_idle && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	initial begin
		#2000000;
		$display("arm_ik_joint_steps verification failed");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extremes, origin of the shoulder, zero over zero, negative x
		send_target(16'd0, 16'd0, 16'd3744);
		send_target(16'd0, 16'd0, 16'd0);
		send_target(16'h8000, 16'h8000, 16'h8000);
		send_target(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_target(16'd0, 16'd1000, 16'd3744);
		send_target(16'd0, -16'sd1000, 16'd3744);
		send_target(-16'sd1000, 16'd500, 16'd3744);
		send_target(-16'sd1000, -16'sd500, 16'd4000);
		send_target(16'd1000, 16'd0, 16'd3744);
		send_target(16'd3584, 16'd0, 16'd3744);
		send_target(16'd3585, 16'd0, 16'd3744);
		send_target(16'd0, 16'd0, 16'd7328);
		send_target(16'd500, 16'd500, 16'd2000);
		drain();
		write_reg(REG_LINK_LENGTH, 32'd0);
		write_reg(REG_BASE_HEIGHT, 32'd0);
		send_target(16'd0, 16'd0, 16'd0);
		send_target(16'd1, 16'd0, 16'd0);
		drain();
		write_reg(REG_LINK_LENGTH, 32'h7FFF);
		write_reg(REG_BASE_CPR, 32'hFFFF);
		write_reg(REG_SHOULDER_CPR, 32'hFFFF);
		write_reg(REG_ELBOW_CPR, 32'hFFFF);
		send_target(16'h8000, 16'h8000, 16'h8000);
		send_target(16'h7FFF, 16'h8000, 16'h7FFF);
		send_target(-16'sd3, 16'd7, 16'd5);
		random_targets(200, 32767);
		drain();
		write_reg(REG_BASE_HEIGHT, 32'h7FFF);
		write_reg(REG_BASE_CPR, 32'd0);
		write_reg(REG_SHOULDER_CPR, 32'd0);
		write_reg(REG_ELBOW_CPR, 32'd0);
		random_targets(150, 32767);
		drain();
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_BASE_HEIGHT, 32'd3744);
			write_reg(REG_LINK_LENGTH, $urandom_range(1, 12000));
			write_reg(REG_BASE_CPR, $urandom_range(0, 65535));
			write_reg(REG_SHOULDER_CPR, $urandom_range(0, 65535));
			write_reg(REG_ELBOW_CPR, $urandom_range(0, 65535));
			write_reg(reg_idx_t'(3'd7), $urandom);
			random_targets(300, u_chk.link_length * 2 + 1);
			drain();
		end
		allow_idle = 1'b0;
		random_targets(150, 3584);
		drain();
		if (fail_count == 0)
			$display("arm_ik_joint_steps verification clean");
		else
			$display("arm_ik_joint_steps verification failed");
		$finish;
	end
endmodule

### arm_ik_joint_steps.f
hdl/arm_ik_pkg.sv
hdl/arm_ik_joint_steps.sv
tb/arm_ik_checker.sv
tb/tb.sv
